// ===== rtl/lpfs_pkg.sv =====
// ----------------------------------------------------------------------------
// lpfs_pkg
// shared types and constants of the least pending face selector
// ----------------------------------------------------------------------------
package lpfs_pkg;

    localparam int FACE_W   = 32;
    localparam int RND_W    = 16;
    localparam int OPEND_W  = 16;
    localparam int MOD_CW   = $clog2(RND_W);

    localparam logic [1:0] CMD_CAND    = 2'd0;
    localparam logic [1:0] CMD_SATISFY = 2'd1;
    localparam logic [1:0] CMD_EXPIRE  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_MOD,
        ST_WALK,
        ST_INC,
        ST_OUTPUT
    } lpfs_state_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic scan_run;
        logic update;
        logic mod_start;
        logic mod_step;
        logic walk_start;
        logic walk_run;
        logic inc_write;
        logic out_load;
    } lpfs_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_cand;
        logic is_event;
        logic last;
        logic scan_done;
        logic walk_done;
        logic walk_match;
        logic tie_zero;
        logic mod_last;
        logic out_free;
    } lpfs_stat_t;

endpackage

// ===== rtl/lpfs_ram.sv =====
// ----------------------------------------------------------------------------
// lpfs_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module lpfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/lpfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// lpfs_ctrl
// sequencer: scan, update, modulo, walk, increment, output
// ----------------------------------------------------------------------------
module lpfs_ctrl
    import lpfs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  lpfs_stat_t stat,
    output lpfs_cmd_t  cmd
);

    lpfs_state_t state_reg;
    lpfs_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!stat.is_cand && !stat.is_event)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.scan_done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (stat.is_cand && stat.last)
                begin
                    state_next = ST_MOD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MOD:
            begin
                if (stat.tie_zero)
                begin
                    state_next = ST_OUTPUT;
                end
                else if (stat.mod_last)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (stat.walk_match)
                begin
                    state_next = ST_INC;
                end
                else if (stat.walk_done)
                begin
                    state_next = ST_OUTPUT;
                end
            end
            ST_INC:
            begin
                state_next = ST_OUTPUT;
            end
            ST_OUTPUT:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            ST_SCAN:
            begin
                cmd.scan_run = stat.is_cand || stat.is_event;
            end
            ST_UPDATE:
            begin
                cmd.update    = 1'b1;
                cmd.mod_start = stat.is_cand && stat.last;
            end
            ST_MOD:
            begin
                cmd.mod_step   = !stat.tie_zero;
                cmd.walk_start = !stat.tie_zero && stat.mod_last;
            end
            ST_WALK:
            begin
                cmd.walk_run = 1'b1;
            end
            ST_INC:
            begin
                cmd.inc_write = 1'b1;
            end
            ST_OUTPUT:
            begin
                cmd.out_load = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/lpfs_dp.sv =====
// ----------------------------------------------------------------------------
// lpfs_dp
// face table, request tracking, tie-break modulo unit and output register
// ----------------------------------------------------------------------------
module lpfs_dp
    import lpfs_pkg::*;
#(
    parameter int TABLE_ENTRIES = 32,
    parameter int PENDING_BITS  = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lpfs_cmd_t           cmd,
    output lpfs_stat_t          stat,
    input  logic [1:0]          in_cmd,
    input  logic [FACE_W-1:0]   in_face,
    input  logic                in_last,
    input  logic [RND_W-1:0]    in_rnd,
    input  logic                out_ready,
    output logic                out_valid,
    output logic                out_selected,
    output logic [FACE_W-1:0]   out_face,
    output logic [OPEND_W-1:0]  out_pending
);

    localparam int UW = $clog2(TABLE_ENTRIES + 1);
    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int RW = UW + 1;
    localparam int CW = PENDING_BITS + 1;
    localparam int EW = FACE_W + PENDING_BITS + 1;

    // item registers
    logic [1:0]        cmd_reg;
    logic [FACE_W-1:0] id_reg;
    logic              last_reg;
    logic [RND_W-1:0]  rnd_reg;

    // table bookkeeping
    logic [UW-1:0]            used_reg;
    logic [TABLE_ENTRIES-1:0] inreq_reg;
    logic [CW-1:0]            best_reg;
    logic [UW-1:0]            tie_reg;

    // scan pipeline
    logic [UW-1:0] issue_reg;
    logic          rd_vld_reg;
    logic [IW-1:0] rd_idx_reg;

    // hit / chosen entry
    logic                    hit_reg;
    logic [IW-1:0]           hit_idx_reg;
    logic [FACE_W-1:0]       hit_face_reg;
    logic [PENDING_BITS-1:0] hit_pend_reg;
    logic                    hit_to_reg;
    logic                    sel_reg;

    // modulo unit, remainder doubles as pick counter
    logic [RW-1:0]     rem_reg;
    logic [MOD_CW-1:0] mod_cnt_reg;

    // output register
    logic              out_vld_reg;
    logic              out_sel_reg;
    logic [FACE_W-1:0] out_face_reg;
    logic [OPEND_W-1:0] out_pend_reg;

    // ram ports
    logic                    wr_en;
    logic [IW-1:0]           wr_addr;
    logic [EW-1:0]           wr_data;
    logic                    rd_en;
    logic [EW-1:0]           rd_data;
    logic [FACE_W-1:0]       rd_face;
    logic [PENDING_BITS-1:0] rd_pend;
    logic                    rd_to;
    logic [CW-1:0]           rd_cost;

    logic                    is_cand;
    logic                    is_event;
    logic                    scan_match;
    logic                    walk_hit;
    logic                    walk_match;
    logic                    room;
    logic                    cand_valid;
    logic [IW-1:0]           cand_idx;
    logic [PENDING_BITS-1:0] cand_pend;
    logic                    cand_to;
    logic [CW-1:0]           cand_cost;
    logic [RW-1:0]           rem_shift;
    logic [RW-1:0]           rem_step;
    logic [31:0]             hit_pend_ext;

    function automatic logic [CW-1:0] cost_of(input logic [PENDING_BITS-1:0] p,
                                              input logic t);
        logic [CW-1:0] c;
        c = t ? {p, 1'b0} : {1'b0, p};
        return c;
    endfunction

    assign rd_face = rd_data[FACE_W-1:0];
    assign rd_pend = rd_data[FACE_W +: PENDING_BITS];
    assign rd_to   = rd_data[EW-1];
    assign rd_cost = cost_of(rd_pend, rd_to);

    assign is_cand  = (cmd_reg == CMD_CAND);
    assign is_event = (cmd_reg == CMD_SATISFY) || (cmd_reg == CMD_EXPIRE);

    assign scan_match = rd_vld_reg && (rd_face == id_reg);
    assign walk_hit   = rd_vld_reg && inreq_reg[rd_idx_reg] && (rd_cost == best_reg);
    assign walk_match = walk_hit && (rem_reg == '0);

    assign rd_en = (cmd.scan_run && !scan_match && (issue_reg < used_reg))
                || (cmd.walk_run && !walk_match && (issue_reg < used_reg));

    // candidate that takes part in this request
    assign room       = (used_reg < UW'(TABLE_ENTRIES));
    assign cand_valid = hit_reg || room;
    assign cand_idx   = hit_reg ? hit_idx_reg : used_reg[IW-1:0];
    assign cand_pend  = hit_reg ? hit_pend_reg : '0;
    assign cand_to    = hit_reg ? hit_to_reg : 1'b0;
    assign cand_cost  = cost_of(cand_pend, cand_to);

    // restoring remainder, one quotient bit a cycle
    assign rem_shift = {rem_reg[RW-2:0], rnd_reg[RND_W-1]};
    assign rem_step  = (rem_shift >= {1'b0, tie_reg}) ? (rem_shift - {1'b0, tie_reg})
                                                      : rem_shift;

    assign hit_pend_ext = 32'(hit_pend_reg);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = hit_idx_reg;
        wr_data = {hit_to_reg, hit_pend_reg, hit_face_reg};
        if (cmd.update && is_event && hit_reg)
        begin
            wr_en   = 1'b1;
            wr_data = {(cmd_reg == CMD_EXPIRE),
                       (hit_pend_reg == '0) ? hit_pend_reg : hit_pend_reg - 1'b1,
                       hit_face_reg};
        end
        else if (cmd.update && is_cand && !hit_reg && room)
        begin
            wr_en   = 1'b1;
            wr_addr = used_reg[IW-1:0];
            wr_data = {1'b0, {PENDING_BITS{1'b0}}, id_reg};
        end
        else if (cmd.inc_write)
        begin
            wr_en   = 1'b1;
            wr_data = {hit_to_reg,
                       (hit_pend_reg == '1) ? hit_pend_reg : hit_pend_reg + 1'b1,
                       hit_face_reg};
        end
    end

    lpfs_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (issue_reg[IW-1:0]),
        .rd_data (rd_data)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= '0;
            inreq_reg   <= '0;
            best_reg    <= '1;
            tie_reg     <= '0;
            issue_reg   <= '0;
            rd_vld_reg  <= 1'b0;
            hit_reg     <= 1'b0;
            sel_reg     <= 1'b0;
            mod_cnt_reg <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_item || cmd.walk_start)
            begin
                issue_reg  <= '0;
                rd_vld_reg <= 1'b0;
            end
            else
            begin
                rd_vld_reg <= rd_en;
                if (rd_en)
                begin
                    issue_reg <= issue_reg + 1'b1;
                end
            end

            if (cmd.load_item)
            begin
                hit_reg <= 1'b0;
            end
            else if (cmd.scan_run && scan_match)
            begin
                hit_reg <= 1'b1;
            end

            if (cmd.update && is_cand)
            begin
                if (!hit_reg && room)
                begin
                    used_reg <= used_reg + 1'b1;
                end
                if (cand_valid && !inreq_reg[cand_idx])
                begin
                    inreq_reg[cand_idx] <= 1'b1;
                    if (cand_cost < best_reg)
                    begin
                        best_reg <= cand_cost;
                        tie_reg  <= UW'(1);
                    end
                    else if (cand_cost == best_reg)
                    begin
                        tie_reg <= tie_reg + 1'b1;
                    end
                end
            end

            if (cmd.mod_start)
            begin
                mod_cnt_reg <= '0;
            end
            else if (cmd.mod_step)
            begin
                mod_cnt_reg <= mod_cnt_reg + 1'b1;
            end

            if (cmd.mod_start || cmd.walk_start)
            begin
                sel_reg <= 1'b0;
            end
            else if (cmd.walk_run && walk_match)
            begin
                sel_reg <= 1'b1;
            end

            if (cmd.out_load)
            begin
                out_vld_reg <= 1'b1;
                inreq_reg   <= '0;
                best_reg    <= '1;
                tie_reg     <= '0;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            cmd_reg  <= in_cmd;
            id_reg   <= in_face;
            last_reg <= in_last;
            rnd_reg  <= in_rnd;
        end
        else if (cmd.mod_step)
        begin
            rnd_reg <= {rnd_reg[RND_W-2:0], 1'b0};
        end

        rd_idx_reg <= issue_reg[IW-1:0];

        if ((cmd.scan_run && scan_match) || (cmd.walk_run && walk_match))
        begin
            hit_idx_reg  <= rd_idx_reg;
            hit_face_reg <= rd_face;
            hit_pend_reg <= rd_pend;
            hit_to_reg   <= rd_to;
        end

        if (cmd.mod_start)
        begin
            rem_reg <= '0;
        end
        else if (cmd.mod_step)
        begin
            rem_reg <= rem_step;
        end
        else if (cmd.walk_run && walk_hit && !walk_match)
        begin
            rem_reg <= rem_reg - 1'b1;
        end

        if (cmd.out_load)
        begin
            out_sel_reg  <= sel_reg;
            out_face_reg <= sel_reg ? hit_face_reg : '0;
            out_pend_reg <= sel_reg ? hit_pend_ext[OPEND_W-1:0] : '0;
        end
    end

    always_comb
    begin
        stat            = '0;
        stat.is_cand    = is_cand;
        stat.is_event   = is_event;
        stat.last       = last_reg;
        stat.scan_done  = scan_match || (!rd_vld_reg && (issue_reg == used_reg));
        stat.walk_done  = walk_match || (!rd_vld_reg && (issue_reg == used_reg));
        stat.walk_match = walk_match;
        stat.tie_zero   = (tie_reg == '0);
        stat.mod_last   = (mod_cnt_reg == MOD_CW'(RND_W - 1));
        stat.out_free   = !out_vld_reg || out_ready;
    end

    assign out_valid    = out_vld_reg;
    assign out_selected = out_sel_reg;
    assign out_face     = out_face_reg;
    assign out_pending  = out_pend_reg;

endmodule

// ===== rtl/least_pending_face_selector.sv =====
// ----------------------------------------------------------------------------
// least_pending_face_selector
// picks the upstream face with the lowest cost (pending requests, doubled after a timeout), random tie break
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one word per item: tuser is the command (candidate,
//   satisfied, expired), tdata the face id and random value, tlast marks the
//   final candidate of a request. each run of candidates ends in one m_axis
//   word; satisfied and expired events give no word.
// timing
//   an item is taken in the idle state, then the face table is scanned from
//   its ram, one entry a cycle through the registered read, stopping at the
//   first match, and an update state follows.
//   the final candidate adds a remainder unit (random mod tie count), a
//   second walk with an increment write of the entry it picks, and the
//   output state, which waits while the output register is still full;
//   with no tied candidate the remainder unit and the walk are skipped.
// reset
//   the table is empty after reset and no request is open; table contents
//   are only read below the fill count, so the ram needs no clearing.
// stalls
//   the result sits in an output register; the next item is accepted while
//   it waits, and only a new result is held back until it is taken.
// ----------------------------------------------------------------------------
module least_pending_face_selector
    import lpfs_pkg::*;
#(
    parameter int TABLE_ENTRIES = 32,
    parameter int PENDING_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // face_id [31:0], random_value [47:32]
    input  logic        s_axis_tlast,   // last_candidate
    input  logic [1:0]  s_axis_tuser,   // cmd [1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // selected_face [31:0], selected_pending [47:32]
    output logic        m_axis_tuser    // selected
);

    lpfs_cmd_t  cmd;
    lpfs_stat_t stat;

    logic [FACE_W-1:0]  sel_face;
    logic [OPEND_W-1:0] sel_pend;

    // sequencer
    lpfs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // table, tie-break arithmetic and output word
    lpfs_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .PENDING_BITS  (PENDING_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .in_cmd       (s_axis_tuser),
        .in_face      (s_axis_tdata[31:0]),
        .in_last      (s_axis_tlast),
        .in_rnd       (s_axis_tdata[47:32]),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .out_selected (m_axis_tuser),
        .out_face     (sel_face),
        .out_pending  (sel_pend)
    );

    assign m_axis_tdata = {sel_pend, sel_face};

endmodule

// ===== bench/least_pending_face_selector_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// least_pending_face_selector_tb
// self-checking bench for the least pending face selector
// ----------------------------------------------------------------------------
// a directed opening walks the corner cases of the face table, then random
// requests, events and noise follow. a model of the face table inside the
// bench predicts every pick as words are accepted. the monitor compares
// each output word against the oldest prediction. the sender works in
// bursts, the receiver stalls on its own pattern and holds off for long
// stretches twice, so the block backs up into its input.
// ----------------------------------------------------------------------------
module least_pending_face_selector_tb;

    import lpfs_pkg::*;

    localparam int TBL            = 32;
    localparam int PEND_W         = 16;
    localparam int POOL_SIZE      = 40;
    localparam int ITEMS          = 1100;
    localparam int HOLDOFF_CYCLES = 3000;
    localparam int SETTLE_CYCLES  = 2 * TBL + 40;
    localparam longint LIMIT_NS   = 64'd20_000_000;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // receiver stall patterns
    localparam int RX_FREE = 0;
    localparam int RX_COIN = 1;
    localparam int RX_SLOW = 2;

    typedef struct {
        logic [1:0]        cmd;
        logic [FACE_W-1:0] face_id;
        logic              last;
        logic [RND_W-1:0]  rnd;
        bit                drain;     // hold this word back until every pick is out
    } face_item_t;

    typedef struct {
        logic                selected;
        logic [FACE_W-1:0]   face;
        logic [OPEND_W-1:0]  pending;
    } pick_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [47:0]        s_axis_tdata = '0;   // face_id [31:0], random_value [47:32]
    logic               s_axis_tlast = 1'b0; // last_candidate
    logic [1:0]         s_axis_tuser = '0;   // cmd [1:0]
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [47:0]        m_axis_tdata;        // selected_face [31:0], selected_pending [47:32]
    logic               m_axis_tuser;        // selected

    // bench copy of the face table
    logic [FACE_W-1:0]  face_tab  [TBL];
    logic [PEND_W-1:0]  pend_tab  [TBL];
    logic               tmo_tab   [TBL];
    logic               inreq_tab [TBL];
    int                 fill_cnt;
    logic [PEND_W:0]    min_cost;
    int                 ties;

    face_item_t         item_q[$];
    pick_t              pick_q[$];
    face_item_t         cur_item;
    logic [FACE_W-1:0]  face_pool [POOL_SIZE];

    int                 errors = 0;
    int                 stim_count = 0;
    int                 total_items = 0;
    int                 picks_predicted = 0;   // driver only
    int                 picks_seen = 0;        // monitor, nonblocking
    int                 items_accepted = 0;    // driver, nonblocking
    int                 burst_left = 1;
    int                 gap_left = 0;
    int                 holdoff_left = 0;
    int                 holdoffs_done = 0;
    int                 rx_mode = RX_FREE;
    int                 rx_phase_left = 0;

    least_pending_face_selector #(
        .TABLE_ENTRIES (TBL),
        .PENDING_BITS  (PEND_W)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // cost of a table entry: pending doubled when the face has timed out
    function automatic logic [PEND_W:0] face_cost(input int idx);
        return {1'b0, pend_tab[idx]} << tmo_tab[idx];
    endfunction

    // advance the table model by one accepted word; returns 1 with the pick
    // when the word closes a request
    function automatic bit predict_pick(input face_item_t it, output pick_t res);
        int idx;
        int pick;
        logic [PEND_W:0] c;
        res = '{1'b0, '0, '0};
        idx = TBL;
        for (int i = 0; i < fill_cnt; i++)
        begin
            if (idx == TBL && face_tab[i] == it.face_id)
                idx = i;
        end
        if (it.cmd == CMD_SATISFY || it.cmd == CMD_EXPIRE)
        begin
            // events for faces not in the table fall through untouched
            if (idx < TBL)
            begin
                if (pend_tab[idx] != 0)
                    pend_tab[idx] = pend_tab[idx] - 1'b1;
                tmo_tab[idx] = (it.cmd == CMD_EXPIRE);
            end
            return 1'b0;
        end
        if (it.cmd != CMD_CAND)
            return 1'b0;
        // a new face joins only while the table has room
        if (idx == TBL && fill_cnt < TBL)
        begin
            idx = fill_cnt;
            face_tab[idx] = it.face_id;
            pend_tab[idx] = '0;
            tmo_tab[idx] = 1'b0;
            fill_cnt++;
        end
        // repeated mention inside one request is ignored
        if (idx < TBL && !inreq_tab[idx])
        begin
            c = face_cost(idx);
            inreq_tab[idx] = 1'b1;
            if (c < min_cost)
            begin
                min_cost = c;
                ties = 1;
            end
            else if (c == min_cost)
                ties++;
        end
        if (!it.last)
            return 1'b0;
        // walk the table again with current costs; an event in between may
        // leave no entry at the chosen position
        if (ties != 0)
        begin
            pick = it.rnd % ties;
            for (int i = 0; i < fill_cnt; i++)
            begin
                if (!res.selected && inreq_tab[i] && face_cost(i) == min_cost)
                begin
                    if (pick == 0)
                    begin
                        res.selected = 1'b1;
                        res.face = face_tab[i];
                        res.pending = pend_tab[i][OPEND_W-1:0];
                        if (pend_tab[i] != '1)
                            pend_tab[i] = pend_tab[i] + 1'b1;
                    end
                    pick--;
                end
            end
        end
        for (int i = 0; i < TBL; i++)
            inreq_tab[i] = 1'b0;
        min_cost = '1;
        ties = 0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        errors++;
    endtask

    task automatic push_item(input logic [1:0] cmd, input logic [FACE_W-1:0] face_id,
                             input logic last, input logic [RND_W-1:0] rnd,
                             input bit drain);
        item_q.push_back('{cmd, face_id, last, rnd, drain});
        // words the block simply drops do not count toward the stimulus
        if (cmd != CMD_UNUSED)
            stim_count++;
    endtask

    // mostly faces from a small pool so the table fills and ties form,
    // now and then a fresh id that is almost surely unknown
    function automatic logic [FACE_W-1:0] pick_face();
        if ($urandom_range(0, 19) == 0)
            return $urandom;
        return face_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // driver: one word at a time off the pending queue, in bursts
    always @(posedge clk)
    begin
        bit    next_valid;
        bit    got;
        pick_t res;
        if (rst_n)
        begin
            next_valid = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                got = predict_pick(cur_item, res);
                if (got)
                begin
                    pick_q.push_back(res);
                    picks_predicted++;
                end
                items_accepted <= items_accepted + 1;
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (gap_left != 0)
                    gap_left--;
                else if (item_q.size() != 0 &&
                         (!item_q[0].drain || picks_predicted == picks_seen))
                begin
                    cur_item = item_q.pop_front();
                    s_axis_tuser <= cur_item.cmd;
                    s_axis_tdata <= {cur_item.rnd, cur_item.face_id};
                    s_axis_tlast <= cur_item.last;
                    next_valid = 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
                    end
                end
            end
            s_axis_tvalid <= next_valid;
        end
    end

    // long receiver hold-offs once enough words have gone in
    always @(posedge clk)
    begin
        if (holdoff_left != 0)
            holdoff_left <= holdoff_left - 1;
        else if (holdoffs_done < 2 && items_accepted >= 300 + 400 * holdoffs_done)
        begin
            holdoff_left <= HOLDOFF_CYCLES;
            holdoffs_done <= holdoffs_done + 1;
        end
    end

    // receiver: phases of free flow, coin-flip and slow draining
    always @(posedge clk)
    begin
        bit rdy;
        if (rst_n)
        begin
            if (rx_phase_left == 0)
            begin
                rx_mode = $urandom_range(RX_FREE, RX_SLOW);
                rx_phase_left = $urandom_range(20, 400);
            end
            else
                rx_phase_left--;
            case (rx_mode)
                RX_FREE: rdy = 1'b1;
                RX_COIN: rdy = ($urandom_range(0, 1) == 1);
                default: rdy = ($urandom_range(0, 3) == 0);
            endcase
            m_axis_tready <= rdy && (holdoff_left == 0);
        end
    end

    // monitor: every output word against the oldest predicted pick
    always @(posedge clk)
    begin
        pick_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pick_q.size() == 0)
                report_mismatch("output word with no pick pending");
            else
            begin
                want = pick_q.pop_front();
                if (m_axis_tuser !== want.selected)
                    report_mismatch($sformatf("selected got %b want %b",
                                              m_axis_tuser, want.selected));
                if (m_axis_tdata[31:0] !== want.face)
                    report_mismatch($sformatf("selected_face got %h want %h",
                                              m_axis_tdata[31:0], want.face));
                if (m_axis_tdata[47:32] !== want.pending)
                    report_mismatch($sformatf("selected_pending got %0d want %0d",
                                              m_axis_tdata[47:32], want.pending));
            end
            picks_seen <= picks_seen + 1;
        end
    end

    initial
    begin
        #(LIMIT_NS);
        $display("least_pending_face_selector verification failed");
        $finish;
    end

    initial
    begin
        int n;
        int r;
        bit first_random;
        logic [FACE_W-1:0] fa;
        logic [FACE_W-1:0] fb;
        logic [FACE_W-1:0] fc;
        logic [FACE_W-1:0] fd;

        for (int i = 0; i < TBL; i++)
            inreq_tab[i] = 1'b0;
        fill_cnt = 0;
        min_cost = '1;
        ties = 0;

        face_pool[0] = '0;
        face_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            face_pool[i] = $urandom;

        fa = '0;
        fb = '1;
        fc = 32'hA5A5_5A5A;
        fd = 32'h5A5A_A5A5;

        // events for faces not yet in the table, and the unused command
        push_item(CMD_SATISFY, 32'h1234_5678, 1'b0, '0, 1'b0);
        push_item(CMD_EXPIRE, fb, 1'b1, '1, 1'b0);
        push_item(CMD_UNUSED, fb, 1'b1, '1, 1'b0);
        // single candidate request
        push_item(CMD_CAND, fa, 1'b1, '0, 1'b0);
        // lowest pending wins, repeated candidate ignored
        push_item(CMD_CAND, fb, 1'b0, '0, 1'b0);
        push_item(CMD_CAND, fa, 1'b0, '0, 1'b0);
        push_item(CMD_CAND, fb, 1'b0, '0, 1'b0);
        push_item(CMD_CAND, fa, 1'b1, '1, 1'b0);
        // timed-out mark and decrement to zero
        push_item(CMD_EXPIRE, fb, 1'b0, '0, 1'b0);
        push_item(CMD_SATISFY, fa, 1'b0, '0, 1'b0);
        // four-way tie, pick the last in table order
        push_item(CMD_CAND, fc, 1'b0, '0, 1'b0);
        push_item(CMD_CAND, fd, 1'b0, '0, 1'b0);
        push_item(CMD_CAND, fa, 1'b0, '0, 1'b0);
        push_item(CMD_CAND, fb, 1'b1, '1, 1'b0);
        // event inside a request drops the cost below the best: no pick
        push_item(CMD_CAND, fd, 1'b0, '0, 1'b0);
        push_item(CMD_EXPIRE, fd, 1'b0, '0, 1'b0);
        push_item(CMD_CAND, fd, 1'b1, 16'd1, 1'b0);
        // event that leaves the cost alone, two-way tie
        push_item(CMD_CAND, fc, 1'b0, '0, 1'b0);
        push_item(CMD_SATISFY, fc, 1'b1, '0, 1'b0);
        push_item(CMD_CAND, fa, 1'b1, 16'h8000, 1'b0);

        // random part; the first word waits for the directed picks to drain
        first_random = 1'b1;
        while (stim_count < ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                // well-formed request, sometimes with an event in the middle
                n = $urandom_range(1, 6);
                for (int k = 0; k < n; k++)
                begin
                    push_item(CMD_CAND, pick_face(), k == n - 1, RND_W'($urandom),
                              first_random || $urandom_range(0, 199) == 0);
                    first_random = 1'b0;
                    if (k != n - 1 && $urandom_range(0, 9) == 0)
                        push_item($urandom_range(0, 1) ? CMD_EXPIRE : CMD_SATISFY,
                                  pick_face(), 1'($urandom), RND_W'($urandom), 1'b0);
                end
            end
            else if (r < 88)
                push_item($urandom_range(0, 1) ? CMD_EXPIRE : CMD_SATISFY,
                          pick_face(), 1'($urandom), RND_W'($urandom), 1'b0);
            else if (r < 93)
                push_item(CMD_UNUSED, $urandom, 1'($urandom), RND_W'($urandom), 1'b0);
            else
            begin
                // broken run: candidates with no last, they join the next request
                n = $urandom_range(1, 3);
                for (int k = 0; k < n; k++)
                    push_item(CMD_CAND, pick_face(), 1'b0, RND_W'($urandom), 1'b0);
            end
        end
        total_items = item_q.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (items_accepted != total_items)
            @(posedge clk);
        while (picks_seen != picks_predicted)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pick_q.size() != 0)
            report_mismatch($sformatf("%0d picks never came out", pick_q.size()));

        if (errors == 0)
            $display("least_pending_face_selector verification clean");
        else
            $display("least_pending_face_selector verification failed");
        $finish;
    end

endmodule
